### hdl/qenc_pkg.sv
// Shared types and constants for the quadrature encoder step block.
// No dependencies; used by qenc_cfg_regs and quadrature_encoder_step_accel.
`timescale 1ns / 1ps

package qenc_pkg;

  // Pending turning direction.
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RAISE = 2'd1,
    DIR_LOWER = 2'd2
  } dir_e;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FAST_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_MEDIUM_INTERVAL = 2'd1;
  localparam logic [1:0] REG_FAST_STEP       = 2'd2;
  localparam logic [1:0] REG_MEDIUM_STEP     = 2'd3;

  // Register reset values.
  localparam logic [15:0] FAST_INTERVAL_RESET   = 16'd80;
  localparam logic [15:0] MEDIUM_INTERVAL_RESET = 16'd150;
  localparam logic [3:0]  FAST_STEP_RESET       = 4'd6;
  localparam logic [3:0]  MEDIUM_STEP_RESET     = 4'd2;

  // Step size reported for slow turning.
  localparam logic [3:0] SLOW_STEP = 4'd1;

  // Resting codes at which a detent is reported.
  localparam logic [1:0] CODE_REST_LOW  = 2'b00;
  localparam logic [1:0] CODE_REST_HIGH = 2'b11;

  // Transitions (previous code, new code) that raise the count.
  localparam logic [3:0] TR_RAISE_0 = 4'b1101;
  localparam logic [3:0] TR_RAISE_1 = 4'b0100;
  localparam logic [3:0] TR_RAISE_2 = 4'b0010;
  localparam logic [3:0] TR_RAISE_3 = 4'b1011;
  // Transitions that lower the count.
  localparam logic [3:0] TR_LOWER_0 = 4'b1110;
  localparam logic [3:0] TR_LOWER_1 = 4'b0111;
  localparam logic [3:0] TR_LOWER_2 = 4'b0001;
  localparam logic [3:0] TR_LOWER_3 = 4'b1000;

  // Configuration register contents handed to the decoder.
  typedef struct packed {
    logic [15:0] fast_interval_ms;
    logic [15:0] medium_interval_ms;
    logic [3:0]  fast_step;
    logic [3:0]  medium_step;
  } cfg_t;

  // Direction implied by a transition; DIR_NONE for transitions that are ignored.
  function automatic dir_e trans_dir(input logic [3:0] trans);
    dir_e dir;
    case (trans)
      TR_RAISE_0, TR_RAISE_1, TR_RAISE_2, TR_RAISE_3: dir = DIR_RAISE;
      TR_LOWER_0, TR_LOWER_1, TR_LOWER_2, TR_LOWER_3: dir = DIR_LOWER;
      default: dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

### hdl/quadrature_encoder_step_accel.sv
// Top level of the quadrature encoder step decoder with speed-dependent step size.
// Depends on qenc_pkg and qenc_cfg_regs.
`timescale 1ns / 1ps

// One pin sample can be taken every clock cycle while the input side does not
// stall. A sample first lands in an input register, where its transition is
// decoded against the stored code; when the sample moves on, the millisecond
// counter and pending direction are updated, and a detent event, if any, is
// written to the output register, so an event passes through the input
// register and then the output register. The input side stalls only while
// a sample that produces an event waits behind an output event that is held.
// The millisecond counter is TIMER_WIDTH bits wide and saturates at all ones.
module quadrature_encoder_step_accel #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        pin_a_i,
  input  logic        pin_b_i,
  input  logic        ms_tick_i,
  // Event request channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        menu_button_o,
  output logic [3:0]  step_size_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CmpW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;

  qenc_pkg::cfg_t cfg;

  qenc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register.
  logic       s1_valid_q;
  logic [1:0] s1_code_q;
  logic       s1_tick_q;

  // Decoder state.
  logic [1:0]               prev_code_q;
  qenc_pkg::dir_e           pend_q;
  logic [TIMER_WIDTH-1:0]   elapsed_q;

  // Output register.
  logic       out_valid_q;
  logic       out_menu_q;
  logic [3:0] out_step_q;

  // Decode signals.
  qenc_pkg::dir_e         trans_d;
  qenc_pkg::dir_e         pend_d;
  logic [TIMER_WIDTH-1:0] elapsed_d;
  logic [CmpW-1:0]        gap;
  logic                   at_rest;
  logic                   ev;
  logic                   s1_advance;
  logic                   in_accept;
  logic [3:0]             step_sel;

  assign in_accept = in_valid_i & ~in_stall_o;

  // Decode the transition and build the event from the held sample.
  always_comb begin
    trans_d   = qenc_pkg::trans_dir({prev_code_q, s1_code_q});
    pend_d    = (trans_d != qenc_pkg::DIR_NONE) ? trans_d : pend_q;
    elapsed_d = (s1_tick_q && (elapsed_q != TimerMax)) ? elapsed_q + 1'b1 : elapsed_q;
    gap       = CmpW'(elapsed_d);
    at_rest   = (s1_code_q == qenc_pkg::CODE_REST_LOW) ||
                (s1_code_q == qenc_pkg::CODE_REST_HIGH);
    ev        = s1_valid_q && (pend_d != qenc_pkg::DIR_NONE) && at_rest;
    if (gap < CmpW'(cfg.fast_interval_ms)) begin
      step_sel = cfg.fast_step;
    end else if (gap < CmpW'(cfg.medium_interval_ms)) begin
      step_sel = cfg.medium_step;
    end else begin
      step_sel = qenc_pkg::SLOW_STEP;
    end
  end

  // The held sample moves on unless its event would overwrite a held output.
  assign s1_advance = s1_valid_q && (!ev || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_code_q <= {pin_a_i, pin_b_i};
      s1_tick_q <= ms_tick_i;
    end
  end

  // Decoder state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_code_q <= 2'b00;
      pend_q      <= qenc_pkg::DIR_NONE;
      elapsed_q   <= '0;
    end else if (s1_advance) begin
      prev_code_q <= s1_code_q;
      if (ev) begin
        pend_q    <= qenc_pkg::DIR_NONE;
        elapsed_q <= '0;
      end else begin
        pend_q    <= pend_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && out_stall_i) || (s1_advance && ev);
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (s1_advance && ev) begin
      out_menu_q <= (pend_d == qenc_pkg::DIR_LOWER);
      out_step_q <= step_sel;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign menu_button_o = out_menu_q;
  assign step_size_o   = out_step_q;

  // An emitted event clears the timer and the pending direction.
  a_event_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && ev |=> (elapsed_q == '0) && (pend_q == qenc_pkg::DIR_NONE))
    else $error("event did not clear decoder state");

  // An event always lands in the output register.
  a_event_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && ev |=> out_valid_q)
    else $error("event lost on the way to the output register");

  // The input side stalls only when an event is blocked by a held output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && ev && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked event");

  // A saturated timer stays saturated until an event clears it.
  a_timer_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elapsed_q == TimerMax) && !(s1_advance && ev) |=> elapsed_q == TimerMax)
    else $error("saturated timer changed without an event");

endmodule

### hdl/qenc_cfg_regs.sv
// APB-style register file holding the interval thresholds and step sizes.
// Depends on qenc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module qenc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output qenc_pkg::cfg_t      cfg_o
);

  qenc_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_interval_ms   <= qenc_pkg::FAST_INTERVAL_RESET;
      cfg_q.medium_interval_ms <= qenc_pkg::MEDIUM_INTERVAL_RESET;
      cfg_q.fast_step          <= qenc_pkg::FAST_STEP_RESET;
      cfg_q.medium_step        <= qenc_pkg::MEDIUM_STEP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        qenc_pkg::REG_FAST_INTERVAL:   cfg_q.fast_interval_ms   <= pwdata[15:0];
        qenc_pkg::REG_MEDIUM_INTERVAL: cfg_q.medium_interval_ms <= pwdata[15:0];
        qenc_pkg::REG_FAST_STEP:       cfg_q.fast_step          <= pwdata[3:0];
        qenc_pkg::REG_MEDIUM_STEP:     cfg_q.medium_step        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended.
  always_comb begin
    case (reg_idx)
      qenc_pkg::REG_FAST_INTERVAL:   prdata = {16'd0, cfg_q.fast_interval_ms};
      qenc_pkg::REG_MEDIUM_INTERVAL: prdata = {16'd0, cfg_q.medium_interval_ms};
      qenc_pkg::REG_FAST_STEP:       prdata = {28'd0, cfg_q.fast_step};
      qenc_pkg::REG_MEDIUM_STEP:     prdata = {28'd0, cfg_q.medium_step};
      default:                       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sim/quadrature_encoder_step_accel_tb.sv
// Self-checking testbench for quadrature_encoder_step_accel: drives pin samples and
// checks detent event requests against a cycle-free predictor of the decoder.
// Depends on qenc_pkg and the quadrature_encoder_step_accel RTL.
`timescale 1ns / 1ps

module quadrature_encoder_step_accel_tb;

  localparam int TIMER_W        = 8;
  localparam int TIMER_MAX      = (1 << TIMER_W) - 1;
  localparam int DRAIN_CYCLES   = 4;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int PHASE_STEPS    = 55;

  // Codes between the two resting codes, named after the channel that is high.
  localparam logic [1:0] CODE_A_ONLY = 2'b10;
  localparam logic [1:0] CODE_B_ONLY = 2'b01;

  // One detent event request as seen on the output channel.
  typedef struct packed {
    logic       menu_button;
    logic [3:0] step_size;
  } detent_t;

  // One row of the directed sequence; fixed rows carry a hand-written expectation.
  typedef struct packed {
    logic       pin_a;
    logic       pin_b;
    logic       tick;
    logic       fixed;
    logic       fires;
    logic       menu;
    logic [3:0] step;
  } sample_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        pin_a_i = 1'b0;
  logic        pin_b_i = 1'b0;
  logic        ms_tick_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        menu_button_o;
  logic [3:0]  step_size_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the configuration registers and of the decoder state.
  qenc_pkg::cfg_t     cfg_mirror = '{qenc_pkg::FAST_INTERVAL_RESET,
                                     qenc_pkg::MEDIUM_INTERVAL_RESET,
                                     qenc_pkg::FAST_STEP_RESET,
                                     qenc_pkg::MEDIUM_STEP_RESET};
  logic [1:0]         model_code = qenc_pkg::CODE_REST_LOW;
  qenc_pkg::dir_e     model_dir = qenc_pkg::DIR_NONE;
  logic [TIMER_W-1:0] model_elapsed = '0;

  detent_t expected_detents[$];
  int      mismatches = 0;
  int      src_max_gap = 0;
  int      sink_max_gap = 0;
  int      sink_hold_len = 0;
  int      tick_pct = 50;

  // Directed sequence, starting from the reset state with the reset settings.
  sample_row_t directed_rows [18] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0},  // no transition, nothing pending
    '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0},  // lowering step, not at rest
    '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 4'd6},  // first detent, gap counted from reset
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0},  // dwell with a tick
    '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0},  // illegal jump, ignored
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0},  // illegal jump keeps the pending raise
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0},  // later step overrides the direction
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0}
  };

  quadrature_encoder_step_accel #(
    .TIMER_WIDTH(TIMER_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pin_a_i      (pin_a_i),
    .pin_b_i      (pin_b_i),
    .ms_tick_i    (ms_tick_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .menu_button_o(menu_button_o),
    .step_size_o  (step_size_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // Advance the decoder state by one sample; returns 1 when a detent is reported.
  function automatic bit predict_detent(input logic a, input logic b, input logic tick,
                                        output detent_t ev);
    logic [1:0] code;
    logic [3:0] trans;
    code = {a, b};
    trans = {model_code, code};
    ev = '0;
    if (tick && model_elapsed != '1) model_elapsed++;
    case (trans)
      qenc_pkg::TR_RAISE_0, qenc_pkg::TR_RAISE_1,
      qenc_pkg::TR_RAISE_2, qenc_pkg::TR_RAISE_3: model_dir = qenc_pkg::DIR_RAISE;
      qenc_pkg::TR_LOWER_0, qenc_pkg::TR_LOWER_1,
      qenc_pkg::TR_LOWER_2, qenc_pkg::TR_LOWER_3: model_dir = qenc_pkg::DIR_LOWER;
      default: ;
    endcase
    model_code = code;
    if (model_dir == qenc_pkg::DIR_NONE ||
        (code != qenc_pkg::CODE_REST_LOW && code != qenc_pkg::CODE_REST_HIGH))
      return 1'b0;
    // The fast class is tested first, whatever the order of the thresholds.
    if (model_elapsed < cfg_mirror.fast_interval_ms) ev.step_size = cfg_mirror.fast_step;
    else if (model_elapsed < cfg_mirror.medium_interval_ms)
      ev.step_size = cfg_mirror.medium_step;
    else ev.step_size = qenc_pkg::SLOW_STEP;
    ev.menu_button = (model_dir == qenc_pkg::DIR_LOWER);
    model_elapsed = '0;
    model_dir = qenc_pkg::DIR_NONE;
    return 1'b1;
  endfunction

  // Next code along the quadrature cycle: raising runs 00, 10, 11, 01, 00.
  function automatic logic [1:0] next_code(input logic [1:0] code, input bit raise);
    case (code)
      qenc_pkg::CODE_REST_LOW:  return raise ? CODE_A_ONLY : CODE_B_ONLY;
      CODE_A_ONLY:              return raise ? qenc_pkg::CODE_REST_HIGH
                                             : qenc_pkg::CODE_REST_LOW;
      qenc_pkg::CODE_REST_HIGH: return raise ? CODE_B_ONLY : CODE_A_ONLY;
      default:                  return raise ? qenc_pkg::CODE_REST_LOW
                                             : qenc_pkg::CODE_REST_HIGH;
    endcase
  endfunction

  function automatic logic draw_tick();
    return $urandom_range(99, 0) < tick_pct;
  endfunction

  // Offer one sample request after a random gap and hold it until it is taken.
  task automatic offer_sample(input logic a, input logic b, input logic tick);
    int gap;
    gap = (src_max_gap > 0) ? $urandom_range(src_max_gap, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_a_i    <= a;
    pin_b_i    <= b;
    ms_tick_i  <= tick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic a, input logic b, input logic tick);
    detent_t ev;
    offer_sample(a, b, tick);
    if (predict_detent(a, b, tick, ev)) expected_detents.push_back(ev);
  endtask

  task automatic send_step(input bit raise, input logic tick);
    logic [1:0] code;
    code = next_code(model_code, raise);
    send_sample(code[1], code[0], tick);
  endtask

  // Turn until the next resting code, which always reports a detent.
  task automatic turn_to_detent(input bit raise);
    if (model_code != qenc_pkg::CODE_REST_LOW && model_code != qenc_pkg::CODE_REST_HIGH)
    begin
      send_step(raise, 1'b0);
    end else begin
      send_step(raise, 1'b0);
      send_step(raise, 1'b0);
    end
  endtask

  // Stop offering requests until every expected event has arrived and the
  // pipeline has emptied.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_detents.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      qenc_pkg::REG_FAST_INTERVAL:   cfg_mirror.fast_interval_ms = value[15:0];
      qenc_pkg::REG_MEDIUM_INTERVAL: cfg_mirror.medium_interval_ms = value[15:0];
      qenc_pkg::REG_FAST_STEP:       cfg_mirror.fast_step = value[3:0];
      default:                       cfg_mirror.medium_step = value[3:0];
    endcase
  endtask

  // Rewrite all four registers once the block is idle; upper bits carry noise.
  task automatic configure(input logic [15:0] fast_int, input logic [15:0] med_int,
                           input logic [3:0] fast_stp, input logic [3:0] med_stp);
    wait_idle();
    apb_write(qenc_pkg::REG_FAST_INTERVAL,   {16'($urandom()), fast_int});
    apb_write(qenc_pkg::REG_MEDIUM_INTERVAL, {16'($urandom()), med_int});
    apb_write(qenc_pkg::REG_FAST_STEP,       {28'($urandom()), fast_stp});
    apb_write(qenc_pkg::REG_MEDIUM_STEP,     {28'($urandom()), med_stp});
  endtask

  // Receiver: stalls for a random count before each event request, or for a
  // long hold-off when one is asked for.
  initial begin : event_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_len > 0) begin
        hold = sink_hold_len;
        sink_hold_len = 0;
      end else begin
        hold = (sink_max_gap > 0) ? $urandom_range(sink_max_gap, 0) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    end
  end

  // Compare every accepted event request with the oldest expectation.
  always @(posedge clk_i) begin : event_check
    detent_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_detents.size() == 0) begin
        mismatches++;
        $display("[%0t] unexpected event: expected none, got menu_button %0d step_size %0d",
                 $time, menu_button_o, step_size_o);
      end else begin
        want = expected_detents.pop_front();
        if (menu_button_o !== want.menu_button) begin
          mismatches++;
          $display("[%0t] menu_button mismatch: expected %0d, got %0d",
                   $time, want.menu_button, menu_button_o);
        end
        if (step_size_o !== want.step_size) begin
          mismatches++;
          $display("[%0t] step_size mismatch: expected %0d, got %0d",
                   $time, want.step_size, step_size_o);
        end
      end
    end
  end

  // Hard limit on the length of the run.
  initial begin : watchdog
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    sample_row_t row;
    detent_t     ev;
    bit          fired;
    bit          raise_dir;
    logic [1:0]  code;
    int          r;
    int          counted;
    int          len;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; fixed rows use the typed expectation.
    src_max_gap  = 3;
    sink_max_gap = 3;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_sample(row.pin_a, row.pin_b, row.tick);
      fired = predict_detent(row.pin_a, row.pin_b, row.tick, ev);
      if (row.fixed) begin
        fired = row.fires;
        ev.menu_button = row.menu;
        ev.step_size = row.step;
      end
      if (fired) expected_detents.push_back(ev);
    end

    // Long receiver hold-off while the sender keeps turning, so that the
    // block fills up and stalls its input; then wait for everything.
    src_max_gap = 0;
    sink_hold_len = 300;
    repeat (48) send_step(1'b0, 1'b1);
    wait_idle();

    // Timer extremes: one gap just below the upper threshold, then a
    // saturated timer that matches neither class.
    configure(16'(TIMER_MAX), 16'(TIMER_MAX - 1), 4'd4, 4'd8);
    src_max_gap = 0;
    turn_to_detent(1'b1);
    repeat (TIMER_MAX - 1) send_sample(model_code[1], model_code[0], 1'b1);
    turn_to_detent(1'b1);
    repeat (TIMER_MAX + 5) send_sample(model_code[1], model_code[0], 1'b1);
    turn_to_detent(1'b0);

    // Random phases: mostly clean rotation with random ticks, plus dwell,
    // bounce and illegal jumps.
    raise_dir = 1'b1;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       configure(16'd3, 16'd8, 4'd15, 4'd1);
        1:       configure(16'd0, 16'd6, 4'd9, 4'd0);
        2:       configure(16'd10, 16'd4, 4'd1, 4'd15);
        3:       configure(16'd0, 16'd0, 4'd5, 4'd5);
        4:       configure(16'hFFFF, 16'hFFFF, 4'd7, 4'd3);
        default: configure(16'($urandom_range(16, 0)), 16'($urandom_range(24, 0)),
                           4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)));
      endcase
      src_max_gap  = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 11 : 4);
      sink_max_gap = (p % 4 == 1) ? 0 : 11;
      tick_pct     = $urandom_range(100, 5);
      counted = 0;
      while (counted < PHASE_STEPS) begin
        r = $urandom_range(99, 0);
        if ($urandom_range(99, 0) < 15) raise_dir = !raise_dir;
        if (r < 65) begin
          send_step(raise_dir, draw_tick());
          counted++;
        end else if (r < 80) begin
          len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 1);
          repeat (len) send_sample(model_code[1], model_code[0], draw_tick());
        end else if (r < 90) begin
          send_step(!raise_dir, draw_tick());
          counted++;
        end else begin
          code = 2'($urandom_range(3, 0));
          if (code != model_code) counted++;
          send_sample(code[1], code[0], draw_tick());
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_detents.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
